### hw/rtl/tat_pkg.sv
// Shared constants and types for the accelerometer tilt angle pipeline.
// No dependencies; imported by tat_lane and accel_tilt_angles.
`default_nettype none
package tat_pkg;

    localparam int SQRT_STEPS  = 31;
    localparam int CORDIC_STEPS = 30;
    localparam int LATENCY     = 1 + SQRT_STEPS + 1 + CORDIC_STEPS + 4;

    localparam logic signed [15:0] ANGLE_FULL = 16'sd23040;
    localparam logic signed [19:0] DEG_MUL    = 20'sd366688;
    localparam logic [51:0]        DIV_HALF   = 52'd13421772800;
    localparam logic [21:0]        RECIP_25   = 22'd2684355;

    typedef struct packed {
        logic zero;
        logic pos;
        logic neg;
    } t_tag;

    function automatic logic signed [32:0] atan_q30(input int idx);
        logic signed [32:0] val;
        case (idx)
            0:  val = 33'sd843314857;
            1:  val = 33'sd497837829;
            2:  val = 33'sd263043837;
            3:  val = 33'sd133525159;
            4:  val = 33'sd67021687;
            5:  val = 33'sd33543516;
            6:  val = 33'sd16775851;
            7:  val = 33'sd8388437;
            8:  val = 33'sd4194283;
            9:  val = 33'sd2097149;
            default: val = 33'sd1 <<< (30 - idx);
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/tat_lane.sv
// One tilt angle lane: squared magnitude, pipelined square root, CORDIC
// arctangent and degree conversion. Depends on tat_pkg.
`default_nettype none
module tat_lane
    import tat_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [16:0] i_num,
    input  wire logic signed [15:0] i_b1,
    input  wire logic signed [15:0] i_b2,
    output logic signed [15:0]      o_angle
);

    logic [31:0]        r_sq   [SQRT_STEPS+1];
    logic [32:0]        r_rem  [SQRT_STEPS+1];
    logic [30:0]        r_root [SQRT_STEPS+1];
    logic signed [16:0] r_num  [SQRT_STEPS+1];
    t_tag               r_tag  [SQRT_STEPS+CORDIC_STEPS+5];

    logic signed [35:0] r_x [CORDIC_STEPS+1];
    logic signed [35:0] r_y [CORDIC_STEPS+1];
    logic signed [32:0] r_z [CORDIC_STEPS+1];

    logic signed [52:0] r_prod;
    logic [20:0]        r_u;
    logic               r_sgn1;
    logic               r_sgn2;
    logic [42:0]        r_q;
    logic signed [15:0] r_angle;

    logic signed [31:0] n_sq1;
    logic signed [31:0] n_sq2;

    assign n_sq1 = i_b1 * i_b1;
    assign n_sq2 = i_b2 * i_b2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq[0]      <= 32'(unsigned'(n_sq1)) + 32'(unsigned'(n_sq2));
            r_rem[0]     <= '0;
            r_root[0]    <= '0;
            r_num[0]     <= i_num;
            r_tag[0].zero <= (i_b1 == '0) && (i_b2 == '0);
            r_tag[0].pos  <= !i_num[16] && (i_num != '0);
            r_tag[0].neg  <= i_num[16];
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [1:0]  pair;
        logic [34:0] cur;
        logic [34:0] trial;
        if (k <= 15) begin : g_data
            assign pair = r_sq[k][31-2*k -: 2];
        end else begin : g_pad
            assign pair = 2'b00;
        end
        assign cur   = {r_rem[k], pair};
        assign trial = {2'b00, r_root[k], 2'b01};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[k+1]  <= r_sq[k];
                r_num[k+1] <= r_num[k];
                r_tag[k+1] <= r_tag[k];
                if (cur >= trial) begin
                    r_rem[k+1]  <= 33'(cur - trial);
                    r_root[k+1] <= {r_root[k][29:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= cur[32:0];
                    r_root[k+1] <= {r_root[k][29:0], 1'b0};
                end
            end
        end
    end

    logic [31:0] n_x0;
    assign n_x0 = {1'b0, r_root[SQRT_STEPS]}
                + 32'(r_rem[SQRT_STEPS] > {2'b00, r_root[SQRT_STEPS]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= {4'b0000, n_x0};
            r_y[0] <= {{4{r_num[SQRT_STEPS][16]}}, r_num[SQRT_STEPS], 15'b0};
            r_z[0] <= '0;
            r_tag[SQRT_STEPS+1] <= r_tag[SQRT_STEPS];
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [35:0] xs;
        logic signed [35:0] ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[SQRT_STEPS+2+i] <= r_tag[SQRT_STEPS+1+i];
                if (!r_y[i][35]) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + atan_q30(i);
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - atan_q30(i);
                end
            end
        end
    end

    localparam int TB = SQRT_STEPS + CORDIC_STEPS + 1;

    logic [51:0] n_abs;
    logic [51:0] n_rnd;
    logic [16:0] n_mag;
    logic [15:0] n_lim;
    assign n_abs = r_prod[52] ? 52'(-r_prod) : r_prod[51:0];
    assign n_rnd = n_abs + DIV_HALF;
    assign n_mag = r_q[42:26];
    assign n_lim = (n_mag > 17'(ANGLE_FULL)) ? ANGLE_FULL : n_mag[15:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod      <= r_z[CORDIC_STEPS] * DEG_MUL;
            r_tag[TB+1] <= r_tag[TB];
            r_u         <= n_rnd[50:30];
            r_sgn1      <= r_prod[52];
            r_tag[TB+2] <= r_tag[TB+1];
            r_q         <= r_u * RECIP_25;
            r_sgn2      <= r_sgn1;
            r_tag[TB+3] <= r_tag[TB+2];
            if (r_tag[TB+3].zero) begin
                r_angle <= r_tag[TB+3].pos ? ANGLE_FULL
                         : (r_tag[TB+3].neg ? -ANGLE_FULL : 16'sd0);
            end else begin
                r_angle <= r_sgn2 ? -signed'(n_lim) : signed'(n_lim);
            end
        end
    end

    assign o_angle = r_angle;

endmodule
`default_nettype wire

### hw/rtl/accel_tilt_angles.sv
// Top level of the accelerometer tilt angle block: handshake control and
// two tat_lane instances for roll and pitch. Depends on tat_pkg and tat_lane.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_stall    i_accel_x, i_accel_y, i_accel_z
//   output   out        o_valid / i_stall    o_roll_angle, o_pitch_angle
//
// One transaction enters per cycle while the output is not stalled; each
// result passes the 31-step square root and 30-step CORDIC pipelines.
// A stalled result at the output freezes the whole pipeline for that cycle.
// Reset clears only the valid bits of the pipeline.
`default_nettype none
module accel_tilt_angles
    import tat_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_accel_x,
    input  wire logic signed [15:0] i_accel_y,
    input  wire logic signed [15:0] i_accel_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_roll_angle,
    output logic signed [15:0]      o_pitch_angle
);

    logic [LATENCY-1:0] r_vld;
    logic               en;
    logic signed [16:0] neg_x;

    assign en      = !(r_vld[LATENCY-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LATENCY-1];
    assign neg_x   = -{i_accel_x[15], i_accel_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LATENCY-2:0], i_valid};
        end
    end

    tat_lane u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   ({i_accel_y[15], i_accel_y}),
        .i_b1    (i_accel_z),
        .i_b2    (i_accel_x),
        .o_angle (o_roll_angle)
    );

    tat_lane u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   (neg_x),
        .i_b1    (i_accel_z),
        .i_b2    (i_accel_y),
        .o_angle (o_pitch_angle)
    );

endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for accel_tilt_angles: directed and random triples,
// predicted roll and pitch angles compared against the block outputs.
// Depends on tat_pkg and the accel_tilt_angles RTL.
`default_nettype none
module testbench;
    import tat_pkg::*;

    localparam int N_RANDOM   = 400;
    localparam int MAX_REPORT = 10;
    localparam int ITERS      = 30;
    localparam longint TILT_DIV = 64'sd26843545600;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               known;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
    } t_row;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
    } t_angles;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic signed [15:0] i_accel_x = '0;
    logic signed [15:0] i_accel_y = '0;
    logic signed [15:0] i_accel_z = '0;
    logic o_stall, o_valid;
    logic signed [15:0] o_roll_angle, o_pitch_angle;

    t_angles angles_due[$];
    int unsigned mismatches = 0;
    bit sending_done = 1'b0;
    bit long_hold = 1'b0;

    accel_tilt_angles dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_accel_x(i_accel_x), .i_accel_y(i_accel_y), .i_accel_z(i_accel_z),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_roll_angle(o_roll_angle), .o_pitch_angle(o_pitch_angle)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint unsigned root_rounded(input longint unsigned s);
        longint unsigned r, bitv, v;
        r = 0;
        bitv = 64'd1 << 62;
        v = s;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        if (s - r * r > r) r++;
        return r;
    endfunction

    function automatic longint tilt_angle(input longint num, input longint b1,
                                          input longint b2);
        longint unsigned sq;
        longint cx, cy, cz, xs, ys, p, q;
        longint steps [ITERS];
        steps = '{843314857, 497837829, 263043837, 133525159, 67021687,
                  33543516, 16775851, 8388437, 4194283, 2097149,
                  1048576, 524288, 262144, 131072, 65536, 32768, 16384,
                  8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
        sq = b1 * b1 + b2 * b2;
        if (sq == 0) return (num > 0) ? 23040 : (num < 0) ? -23040 : 0;
        cx = longint'(root_rounded(sq << 30));
        cy = num * 32768;
        cz = 0;
        for (int i = 0; i < ITERS; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy >= 0) begin
                cx = cx + ys; cy = cy - xs; cz += steps[i];
            end else begin
                cx = cx - ys; cy = cy + xs; cz -= steps[i];
            end
        end
        p = cz * 366688;
        if (p >= 0) q = (p + TILT_DIV / 2) / TILT_DIV;
        else q = -((-p + TILT_DIV / 2) / TILT_DIV);
        if (q > 23040) q = 23040;
        if (q < -23040) q = -23040;
        return q;
    endfunction

    function automatic t_angles predict_angles(input logic signed [15:0] x,
                                               input logic signed [15:0] y,
                                               input logic signed [15:0] z);
        t_angles a;
        longint lx, ly, lz;
        lx = x; ly = y; lz = z;
        a.roll  = 16'(tilt_angle(ly, lz, lx));
        a.pitch = 16'(tilt_angle(-lx, lz, ly));
        return a;
    endfunction

    task automatic send_triple(input t_row r);
        t_angles a;
        int gap;
        a = predict_angles(r.x, r.y, r.z);
        if (r.known) begin
            a.roll = r.roll;
            a.pitch = r.pitch;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 1) == 0) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_accel_x <= r.x;
        i_accel_y <= r.y;
        i_accel_z <= r.z;
        angles_due.push_back(a);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 7)) - 16'sd3;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_row table_rows[$];
        t_row r;
        table_rows = '{
            '{16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
            '{16'sd0, 16'sd100, 16'sd0, 1'b1, 16'sd23040, 16'sd0},
            '{16'sd0, -16'sd100, 16'sd0, 1'b1, -16'sd23040, 16'sd0},
            '{16'sd100, 16'sd0, 16'sd0, 1'b1, 16'sd0, -16'sd23040},
            '{-16'sd100, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd23040},
            '{16'sh8000, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd23040},
            '{16'sd0, 16'sd0, 16'sd1, 1'b1, 16'sd0, 16'sd0},
            '{16'sd0, 16'sd0, 16'sh8000, 1'b1, 16'sd0, 16'sd0},
            '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 16'sd0, 16'sd0},
            '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 16'sd0, 16'sd0},
            '{16'sh8000, 16'sh7fff, 16'sd1, 1'b0, 16'sd0, 16'sd0},
            '{16'sh7fff, 16'sh8000, -16'sd1, 1'b0, 16'sd0, 16'sd0},
            '{16'sd1, 16'sd1, 16'sd0, 1'b0, 16'sd0, 16'sd0},
            '{16'sd0, 16'sd1, 16'sd1, 1'b0, 16'sd0, 16'sd0},
            '{16'sd1, 16'sd0, -16'sd1, 1'b0, 16'sd0, 16'sd0},
            '{16'sd0, 16'sd0, 16'sd16384, 1'b0, 16'sd0, 16'sd0},
            '{16'sd1000, -16'sd2000, 16'sd16384, 1'b0, 16'sd0, 16'sd0},
            '{-16'sd1, 16'sh7fff, 16'sd0, 1'b0, 16'sd0, 16'sd0}
        };
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (table_rows[k]) send_triple(table_rows[k]);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) long_hold = 1'b1;
            r.x = rand_axis();
            r.y = rand_axis();
            r.z = rand_axis();
            r.known = 1'b0;
            r.roll = '0;
            r.pitch = '0;
            send_triple(r);
        end
        i_valid <= 1'b0;
        sending_done = 1'b1;
        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        int wait_cycles;
        while (!sending_done) begin
            @(negedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                i_stall <= 1'b1;
                repeat (200) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                wait_cycles = $urandom_range(0, 16);
                i_stall <= (wait_cycles != 0);
                repeat (wait_cycles) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_angles want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (angles_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("Unexpected transaction: roll %0d pitch %0d",
                             o_roll_angle, o_pitch_angle);
            end else begin
                want = angles_due.pop_front();
                if (want.roll !== o_roll_angle || want.pitch !== o_pitch_angle) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("Mismatch: roll %0d/%0d pitch %0d/%0d (exp/act)",
                                 want.roll, o_roll_angle, want.pitch, o_pitch_angle);
                end
            end
        end
    end

    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
